@@ hdl/tlca_pkg.sv @@
package tlca_pkg;

  localparam int NODE_W     = 10;
  localparam int MAX_NODES  = 1024;
  localparam int LEVELS     = 10;
  localparam int LVL_W      = 4;
  localparam int CNT_W      = 11;
  localparam int JADDR_W    = LVL_W + NODE_W;
  localparam int JDEPTH     = LEVELS * MAX_NODES;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int USER_W     = 2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_LCA   = 2'd2,
    FUNC_ANC   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_BUILD = 2'd0,
    KIND_LCA   = 2'd1,
    KIND_ANC   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    JA_BLD1,
    JA_BLD2,
    JA_CLB,
    JA_X,
    JA_Y,
    JA_FIN
  } jaddr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_X,
    RES_CX,
    RES_JRD
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD1,
    ST_BLD_RD2,
    ST_BLD_WR,
    ST_CLB_STEP,
    ST_CLB_WAIT,
    ST_LCA_DA,
    ST_LCA_DB,
    ST_LCA_DIF,
    ST_LCA_EQ,
    ST_LCA_RX,
    ST_LCA_RY,
    ST_LCA_CMP,
    ST_LCA_FIN,
    ST_LCA_ANS,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       load_wr;
    logic       jrd_en;
    jaddr_sel_t jrd_sel;
    logic       drd_en;
    logic       drd_y;
    logic       bld_wr;
    logic       bld_next_j;
    logic       bld_next_lvl;
    logic       clb_take;
    logic       dbl_set;
    logic       clb_adv;
    logic       dx_load;
    logic       dif_start;
    logic       clb_back;
    logic       lv_init;
    logic       px_load;
    logic       cmp_upd;
    logic       res_load;
    res_sel_t   res_sel;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic step_bit;
    logic beyond;
    logic dbl;
    logic depth_lt;
    logic depth_gt;
    logic x_eq_y;
    logic k_zero;
    logic j_last;
    logic lvl_last;
    logic ht_one;
    logic is_lca;
  } dp_stat_t;

endpackage

@@ hdl/tlca_dp.sv @@
module tlca_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tlca_pkg::CNT_W-1:0]      cfg_wdata,
  input  logic [tlca_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [tlca_pkg::USER_W-1:0]     in_tuser,
  input  tlca_pkg::dp_cmd_t               cmd,
  output tlca_pkg::dp_stat_t              stat,
  output logic [tlca_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [tlca_pkg::USER_W-1:0]     out_tuser
);
  import tlca_pkg::*;

  node_t f_a, f_b, f_par, f_dep, f_steps;
  func_t f_func;

  cnt_t  n_eff_r;
  lvl_t  ht_r;
  cnt_t  n_clamp;
  lvl_t  ht_calc;

  node_t jmem [JDEPTH];
  node_t dmem [MAX_NODES];
  node_t jrd_r, drd_r;
  logic  [JADDR_W-1:0] jraddr, jwaddr;
  node_t jwdata;
  logic  jwe;

  kind_t kind_r, out_kind_r;
  node_t x_r, y_r, cx_r, px_r, steps_r, dx_r, res_r, j_r, out_node_r;
  lvl_t  k_r, lvl_r, lvl_m1, clvl;
  logic  dbl_r, sel_y_r;

  assign f_a     = in_tdata[NODE_W-1:0];
  assign f_b     = in_tdata[2*NODE_W-1:NODE_W];
  assign f_par   = in_tdata[3*NODE_W-1:2*NODE_W];
  assign f_dep   = in_tdata[4*NODE_W-1:3*NODE_W];
  assign f_steps = in_tdata[5*NODE_W-1:4*NODE_W];
  assign f_func  = func_t'(in_tuser);

  // clamp node count, levels built = ceil(log2(count))
  always_comb begin
    n_clamp = cfg_wdata;
    if (cfg_wdata < CNT_W'(2)) begin
      n_clamp = CNT_W'(2);
    end else if (cfg_wdata > CNT_W'(MAX_NODES)) begin
      n_clamp = CNT_W'(MAX_NODES);
    end
    ht_calc = LVL_W'(1);
    for (int l = 1; l < LEVELS; l++) begin
      if (n_clamp > (CNT_W'(1) << l)) begin
        ht_calc = LVL_W'(l + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r <= CNT_W'(MAX_NODES);
      ht_r    <= LVL_W'(LEVELS);
    end else if (cfg_we) begin
      n_eff_r <= n_clamp;
      ht_r    <= ht_calc;
    end
  end

  assign lvl_m1 = lvl_r - LVL_W'(1);
  assign clvl   = stat.beyond ? (ht_r - LVL_W'(1)) : k_r;

  always_comb begin
    unique case (cmd.jrd_sel)
      JA_BLD1: jraddr = {lvl_m1, j_r};
      JA_BLD2: jraddr = {lvl_m1, jrd_r};
      JA_CLB:  jraddr = {clvl, cx_r};
      JA_X:    jraddr = {k_r, x_r};
      JA_Y:    jraddr = {k_r, y_r};
      JA_FIN:  jraddr = {LVL_W'(0), x_r};
      default: jraddr = '0;
    endcase
  end

  assign jwe    = cmd.load_wr | cmd.bld_wr;
  assign jwaddr = cmd.bld_wr ? {lvl_r, j_r} : {LVL_W'(0), f_a};
  assign jwdata = cmd.bld_wr ? jrd_r : f_par;

  always_ff @(posedge clk) begin
    if (jwe) begin
      jmem[jwaddr] <= jwdata;
    end
    if (cmd.jrd_en) begin
      jrd_r <= jmem[jraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      dmem[f_a] <= f_dep;
    end
    if (cmd.drd_en) begin
      drd_r <= dmem[cmd.drd_y ? y_r : x_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= f_a;
      y_r     <= f_b;
      cx_r    <= f_a;
      steps_r <= f_steps;
      k_r     <= '0;
      dbl_r   <= 1'b0;
      lvl_r   <= LVL_W'(1);
      j_r     <= '0;
      unique case (f_func)
        FUNC_BUILD: kind_r <= KIND_BUILD;
        FUNC_LCA:   kind_r <= KIND_LCA;
        FUNC_ANC:   kind_r <= KIND_ANC;
        default:    kind_r <= kind_r;
      endcase
    end
    if (cmd.bld_next_j) begin
      j_r <= j_r + NODE_W'(1);
    end
    if (cmd.bld_next_lvl) begin
      lvl_r <= lvl_r + LVL_W'(1);
      j_r   <= '0;
    end
    if (cmd.clb_take) begin
      cx_r <= jrd_r;
    end
    if (cmd.dbl_set) begin
      dbl_r <= 1'b1;
    end
    if (cmd.clb_adv) begin
      dbl_r   <= 1'b0;
      steps_r <= steps_r >> 1;
      k_r     <= k_r + LVL_W'(1);
    end
    if (cmd.dx_load) begin
      dx_r <= drd_r;
    end
    if (cmd.dif_start) begin
      k_r   <= '0;
      dbl_r <= 1'b0;
      if (dx_r < drd_r) begin
        cx_r    <= y_r;
        steps_r <= drd_r - dx_r;
        sel_y_r <= 1'b1;
      end else begin
        cx_r    <= x_r;
        steps_r <= dx_r - drd_r;
        sel_y_r <= 1'b0;
      end
    end
    if (cmd.clb_back) begin
      if (sel_y_r) begin
        y_r <= cx_r;
      end else begin
        x_r <= cx_r;
      end
    end
    if (cmd.lv_init) begin
      k_r <= ht_r - LVL_W'(1);
    end
    if (cmd.px_load) begin
      px_r <= jrd_r;
    end
    if (cmd.cmp_upd) begin
      if (px_r != jrd_r) begin
        x_r <= px_r;
        y_r <= jrd_r;
      end
      k_r <= k_r - LVL_W'(1);
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_ZERO: res_r <= '0;
        RES_X:    res_r <= x_r;
        RES_CX:   res_r <= cx_r;
        RES_JRD:  res_r <= jrd_r;
      endcase
    end
    if (cmd.out_load) begin
      out_node_r <= res_r;
      out_kind_r <= kind_r;
    end
  end

  always_comb begin
    stat.steps_zero = (steps_r == '0);
    stat.step_bit   = steps_r[0];
    stat.beyond     = (k_r >= ht_r);
    stat.dbl        = dbl_r;
    stat.depth_lt   = (dx_r < drd_r);
    stat.depth_gt   = (drd_r < dx_r);
    stat.x_eq_y     = (x_r == y_r);
    stat.k_zero     = (k_r == '0);
    stat.j_last     = ({1'b0, j_r} == (n_eff_r - CNT_W'(1)));
    stat.lvl_last   = (lvl_r == (ht_r - LVL_W'(1)));
    stat.ht_one     = (ht_r == LVL_W'(1));
    stat.is_lca     = (kind_r == KIND_LCA);
  end

  assign out_tdata = {(OUT_DATA_W - NODE_W)'(0), out_node_r};
  assign out_tuser = out_kind_r;

endmodule

@@ hdl/tlca_ctrl.sv @@
module tlca_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [tlca_pkg::USER_W-1:0] in_tuser,
  output logic                        in_tready,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output tlca_pkg::dp_cmd_t           cmd,
  input  tlca_pkg::dp_stat_t          stat
);
  import tlca_pkg::*;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   acc, out_free;
  func_t  f_func;

  assign f_func     = func_t'(in_tuser);
  assign in_tready  = (state_r == ST_IDLE);
  assign acc        = in_tvalid & in_tready;
  assign out_free   = ~out_tvalid_r | out_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (f_func)
            FUNC_LOAD:  state_nxt = ST_IDLE;
            FUNC_BUILD: state_nxt = stat.ht_one ? ST_RESULT : ST_BLD_RD1;
            FUNC_LCA:   state_nxt = ST_LCA_DA;
            FUNC_ANC:   state_nxt = ST_CLB_STEP;
          endcase
        end
      end
      ST_BLD_RD1: state_nxt = ST_BLD_RD2;
      ST_BLD_RD2: state_nxt = ST_BLD_WR;
      ST_BLD_WR: begin
        state_nxt = (stat.j_last && stat.lvl_last) ? ST_RESULT : ST_BLD_RD1;
      end
      ST_CLB_STEP: begin
        priority if (stat.steps_zero) begin
          state_nxt = stat.is_lca ? ST_LCA_EQ : ST_RESULT;
        end else if (stat.step_bit) begin
          state_nxt = ST_CLB_WAIT;
        end else begin
          state_nxt = ST_CLB_STEP;
        end
      end
      ST_CLB_WAIT: state_nxt = ST_CLB_STEP;
      ST_LCA_DA:   state_nxt = ST_LCA_DB;
      ST_LCA_DB:   state_nxt = ST_LCA_DIF;
      ST_LCA_DIF: begin
        state_nxt = (stat.depth_lt || stat.depth_gt) ? ST_CLB_STEP : ST_LCA_EQ;
      end
      ST_LCA_EQ:  state_nxt = stat.x_eq_y ? ST_RESULT : ST_LCA_RX;
      ST_LCA_RX:  state_nxt = ST_LCA_RY;
      ST_LCA_RY:  state_nxt = ST_LCA_CMP;
      ST_LCA_CMP: state_nxt = stat.k_zero ? ST_LCA_FIN : ST_LCA_RX;
      ST_LCA_FIN: state_nxt = ST_LCA_ANS;
      ST_LCA_ANS: state_nxt = ST_RESULT;
      ST_RESULT:  state_nxt = out_free ? ST_IDLE : ST_RESULT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.accept  = 1'b1;
          cmd.load_wr = (f_func == FUNC_LOAD);
          if ((f_func == FUNC_BUILD) && stat.ht_one) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
          end
        end
      end
      ST_BLD_RD1: begin
        cmd.jrd_en  = 1'b1;
        cmd.jrd_sel = JA_BLD1;
      end
      ST_BLD_RD2: begin
        cmd.jrd_en  = 1'b1;
        cmd.jrd_sel = JA_BLD2;
      end
      ST_BLD_WR: begin
        cmd.bld_wr = 1'b1;
        priority if (stat.j_last && stat.lvl_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
        end else if (stat.j_last) begin
          cmd.bld_next_lvl = 1'b1;
        end else begin
          cmd.bld_next_j = 1'b1;
        end
      end
      ST_CLB_STEP: begin
        priority if (stat.steps_zero) begin
          if (stat.is_lca) begin
            cmd.clb_back = 1'b1;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_CX;
          end
        end else if (stat.step_bit) begin
          cmd.jrd_en  = 1'b1;
          cmd.jrd_sel = JA_CLB;
        end else begin
          cmd.clb_adv = 1'b1;
        end
      end
      ST_CLB_WAIT: begin
        cmd.clb_take = 1'b1;
        // above the built levels a step is two jumps of the top level
        if (stat.beyond && !stat.dbl) begin
          cmd.dbl_set = 1'b1;
        end else begin
          cmd.clb_adv = 1'b1;
        end
      end
      ST_LCA_DA: begin
        cmd.drd_en = 1'b1;
        cmd.drd_y  = 1'b0;
      end
      ST_LCA_DB: begin
        cmd.dx_load = 1'b1;
        cmd.drd_en  = 1'b1;
        cmd.drd_y   = 1'b1;
      end
      ST_LCA_DIF: begin
        cmd.dif_start = stat.depth_lt | stat.depth_gt;
      end
      ST_LCA_EQ: begin
        if (stat.x_eq_y) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_X;
        end else begin
          cmd.lv_init = 1'b1;
        end
      end
      ST_LCA_RX: begin
        cmd.jrd_en  = 1'b1;
        cmd.jrd_sel = JA_X;
      end
      ST_LCA_RY: begin
        cmd.px_load = 1'b1;
        cmd.jrd_en  = 1'b1;
        cmd.jrd_sel = JA_Y;
      end
      ST_LCA_CMP: begin
        cmd.cmp_upd = 1'b1;
      end
      ST_LCA_FIN: begin
        cmd.jrd_en  = 1'b1;
        cmd.jrd_sel = JA_FIN;
      end
      ST_LCA_ANS: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_JRD;
      end
      ST_RESULT: begin
        cmd.out_load = out_free;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

@@ hdl/tree_lca_binary_lifting.sv @@
// Lowest common ancestor engine for a tree of up to 1024 nodes, by binary lifting. Load items
// write a node's parent and depth and leave the input ready; the root must point to itself. A
// build item fills jump-table levels 1 to L-1, L = ceil(log2(node_count)), then returns a done
// item. An ancestor query walks the climb_steps bits from the lowest, using the jump-table level
// of each set bit; an lca query reads both depths, climbs the deeper node to equal depth, stops
// if the nodes match, else walks the levels from the top down, then reads the final parent. Every
// jump is one read of the jump-table memory, whose read data is registered. One item is worked
// on at a time; a finished result waits in the output register while the next item is accepted.
// The tables are not cleared: querying a node that was never loaded gives an arbitrary answer.
module tree_lca_binary_lifting (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tlca_pkg::CNT_W-1:0]      cfg_wdata,   // node_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tlca_pkg::IN_DATA_W-1:0]  in_tdata,    // node_a, node_b, parent_node,
                                                       // node_depth, climb_steps
  input  logic [tlca_pkg::USER_W-1:0]     in_tuser,    // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tlca_pkg::OUT_DATA_W-1:0] out_tdata,   // answer_node
  output logic [tlca_pkg::USER_W-1:0]     out_tuser    // answer_kind
);
  import tlca_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .stat       (stat)
  );

  tlca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

@@ hdl/tlca_chk.sv @@
module tlca_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tlca_pkg::USER_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tlca_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [tlca_pkg::USER_W-1:0]     out_tuser
);
  import tlca_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_rst_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_BUILD) |-> (out_tdata == '0))
    else $error("build done item carries a node");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != FUNC_LOAD) |=> !in_tready)
    else $error("ready while a command item is in work");

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_LOAD) |=> in_tready)
    else $error("load item stalled the input");

endmodule

bind tree_lca_binary_lifting tlca_chk u_chk (.*);
